### hw/rtl/nvf_pkg.sv
package nvf_pkg;

  // Input and output formats
  localparam int unsigned UNIFORM_BITS  = 32;
  localparam int unsigned OUT_FRAC_BITS = 28;
  localparam int unsigned UNI_SHIFT     = 32 - UNIFORM_BITS;
  localparam int unsigned OUT_SHIFT     = 28 - OUT_FRAC_BITS;

  // Operand widths of the shared multiplier
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Tail handling: first tail index, last index, doubling count limit
  localparam logic [4:0] TAIL_FIRST_IDX = 5'd6;
  localparam logic [4:0] IDX_MAX        = 5'd31;
  localparam logic [5:0] TAIL_LAST_STEP = 6'd32;

  // Decimal scales used to round the tables into Q4.28
  localparam logic [63:0] Q28 = 64'd268435456;
  localparam logic [63:0] E1  = 64'd10;
  localparam logic [63:0] E5  = 64'd100000;
  localparam logic [63:0] E6  = 64'd1000000;
  localparam logic [63:0] E7  = 64'd10000000;
  localparam logic [63:0] E8  = 64'd100000000;
  localparam logic [63:0] E9  = 64'd1000000000;
  localparam logic [63:0] E10 = 64'd10000000000;

  localparam logic [31:0] TAB_A [32] = '{
    32'((64'd0 * Q28 + E1 / 2) / E1),
    32'((64'd3917609 * Q28 + E8 / 2) / E8),
    32'((64'd7841241 * Q28 + E8 / 2) / E8),
    32'((64'd11777 * Q28 + E5 / 2) / E5),
    32'((64'd1573107 * Q28 + E7 / 2) / E7),
    32'((64'd1970991 * Q28 + E7 / 2) / E7),
    32'((64'd2372021 * Q28 + E7 / 2) / E7),
    32'((64'd2776904 * Q28 + E7 / 2) / E7),
    32'((64'd3186394 * Q28 + E7 / 2) / E7),
    32'((64'd36013 * Q28 + E5 / 2) / E5),
    32'((64'd4022501 * Q28 + E7 / 2) / E7),
    32'((64'd4450965 * Q28 + E7 / 2) / E7),
    32'((64'd4887764 * Q28 + E7 / 2) / E7),
    32'((64'd5334097 * Q28 + E7 / 2) / E7),
    32'((64'd5791322 * Q28 + E7 / 2) / E7),
    32'((64'd626099 * Q28 + E6 / 2) / E6),
    32'((64'd6744898 * Q28 + E7 / 2) / E7),
    32'((64'd7245144 * Q28 + E7 / 2) / E7),
    32'((64'd7764218 * Q28 + E7 / 2) / E7),
    32'((64'd8305109 * Q28 + E7 / 2) / E7),
    32'((64'd8871466 * Q28 + E7 / 2) / E7),
    32'((64'd9467818 * Q28 + E7 / 2) / E7),
    32'((64'd100999 * Q28 + E5 / 2) / E5),
    32'((64'd1077516 * Q28 + E6 / 2) / E6),
    32'((64'd1150349 * Q28 + E6 / 2) / E6),
    32'((64'd1229859 * Q28 + E6 / 2) / E6),
    32'((64'd1318011 * Q28 + E6 / 2) / E6),
    32'((64'd1417797 * Q28 + E6 / 2) / E6),
    32'((64'd1534121 * Q28 + E6 / 2) / E6),
    32'((64'd167594 * Q28 + E5 / 2) / E5),
    32'((64'd1862732 * Q28 + E6 / 2) / E6),
    32'((64'd2153875 * Q28 + E6 / 2) / E6)
  };

  localparam logic [31:0] TAB_D [31] = '{
    32'((64'd0 * Q28 + E1 / 2) / E1),
    32'((64'd0 * Q28 + E1 / 2) / E1),
    32'((64'd0 * Q28 + E1 / 2) / E1),
    32'((64'd0 * Q28 + E1 / 2) / E1),
    32'((64'd0 * Q28 + E1 / 2) / E1),
    32'((64'd2636843 * Q28 + E7 / 2) / E7),
    32'((64'd2425085 * Q28 + E7 / 2) / E7),
    32'((64'd2255674 * Q28 + E7 / 2) / E7),
    32'((64'd2116342 * Q28 + E7 / 2) / E7),
    32'((64'd1999243 * Q28 + E7 / 2) / E7),
    32'((64'd1899108 * Q28 + E7 / 2) / E7),
    32'((64'd1812252 * Q28 + E7 / 2) / E7),
    32'((64'd1736014 * Q28 + E7 / 2) / E7),
    32'((64'd1668419 * Q28 + E7 / 2) / E7),
    32'((64'd1607967 * Q28 + E7 / 2) / E7),
    32'((64'd1553497 * Q28 + E7 / 2) / E7),
    32'((64'd1504094 * Q28 + E7 / 2) / E7),
    32'((64'd1459026 * Q28 + E7 / 2) / E7),
    32'((64'd14177 * Q28 + E5 / 2) / E5),
    32'((64'd1379632 * Q28 + E7 / 2) / E7),
    32'((64'd1344418 * Q28 + E7 / 2) / E7),
    32'((64'd1311722 * Q28 + E7 / 2) / E7),
    32'((64'd128126 * Q28 + E6 / 2) / E6),
    32'((64'd1252791 * Q28 + E7 / 2) / E7),
    32'((64'd1226109 * Q28 + E7 / 2) / E7),
    32'((64'd1201036 * Q28 + E7 / 2) / E7),
    32'((64'd1177417 * Q28 + E7 / 2) / E7),
    32'((64'd1155119 * Q28 + E7 / 2) / E7),
    32'((64'd1134023 * Q28 + E7 / 2) / E7),
    32'((64'd1114027 * Q28 + E7 / 2) / E7),
    32'((64'd1095039 * Q28 + E7 / 2) / E7)
  };

  localparam logic [31:0] TAB_T [31] = '{
    32'((64'd7673828 * Q28 + E10 / 2) / E10),
    32'((64'd230687 * Q28 + E8 / 2) / E8),
    32'((64'd3860618 * Q28 + E9 / 2) / E9),
    32'((64'd5438454 * Q28 + E9 / 2) / E9),
    32'((64'd70507 * Q28 + E7 / 2) / E7),
    32'((64'd8708396 * Q28 + E9 / 2) / E9),
    32'((64'd1042357 * Q28 + E8 / 2) / E8),
    32'((64'd1220953 * Q28 + E8 / 2) / E8),
    32'((64'd1408125 * Q28 + E8 / 2) / E8),
    32'((64'd1605579 * Q28 + E8 / 2) / E8),
    32'((64'd181529 * Q28 + E7 / 2) / E7),
    32'((64'd2039573 * Q28 + E8 / 2) / E8),
    32'((64'd2281177 * Q28 + E8 / 2) / E8),
    32'((64'd2543407 * Q28 + E8 / 2) / E8),
    32'((64'd2830296 * Q28 + E8 / 2) / E8),
    32'((64'd3146822 * Q28 + E8 / 2) / E8),
    32'((64'd3499233 * Q28 + E8 / 2) / E8),
    32'((64'd3895483 * Q28 + E8 / 2) / E8),
    32'((64'd4345878 * Q28 + E8 / 2) / E8),
    32'((64'd4864035 * Q28 + E8 / 2) / E8),
    32'((64'd5468334 * Q28 + E8 / 2) / E8),
    32'((64'd6184222 * Q28 + E8 / 2) / E8),
    32'((64'd7047983 * Q28 + E8 / 2) / E8),
    32'((64'd8113195 * Q28 + E8 / 2) / E8),
    32'((64'd9462444 * Q28 + E8 / 2) / E8),
    32'((64'd1123001 * Q28 + E7 / 2) / E7),
    32'((64'd136498 * Q28 + E6 / 2) / E6),
    32'((64'd1716886 * Q28 + E7 / 2) / E7),
    32'((64'd2276241 * Q28 + E7 / 2) / E7),
    32'((64'd330498 * Q28 + E6 / 2) / E6),
    32'((64'd5847031 * Q28 + E7 / 2) / E7)
  };

  localparam logic [31:0] TAB_H [31] = '{
    32'((64'd3920617 * Q28 + E8 / 2) / E8),
    32'((64'd3932705 * Q28 + E8 / 2) / E8),
    32'((64'd3951 * Q28 + E5 / 2) / E5),
    32'((64'd3975703 * Q28 + E8 / 2) / E8),
    32'((64'd4007093 * Q28 + E8 / 2) / E8),
    32'((64'd4045533 * Q28 + E8 / 2) / E8),
    32'((64'd4091481 * Q28 + E8 / 2) / E8),
    32'((64'd4145507 * Q28 + E8 / 2) / E8),
    32'((64'd4208311 * Q28 + E8 / 2) / E8),
    32'((64'd4280748 * Q28 + E8 / 2) / E8),
    32'((64'd4363863 * Q28 + E8 / 2) / E8),
    32'((64'd4458932 * Q28 + E8 / 2) / E8),
    32'((64'd4567523 * Q28 + E8 / 2) / E8),
    32'((64'd4691571 * Q28 + E8 / 2) / E8),
    32'((64'd4833487 * Q28 + E8 / 2) / E8),
    32'((64'd4996298 * Q28 + E8 / 2) / E8),
    32'((64'd5183859 * Q28 + E8 / 2) / E8),
    32'((64'd5401138 * Q28 + E8 / 2) / E8),
    32'((64'd5654656 * Q28 + E8 / 2) / E8),
    32'((64'd595313 * Q28 + E7 / 2) / E7),
    32'((64'd6308489 * Q28 + E8 / 2) / E8),
    32'((64'd6737503 * Q28 + E8 / 2) / E8),
    32'((64'd7264544 * Q28 + E8 / 2) / E8),
    32'((64'd7926471 * Q28 + E8 / 2) / E8),
    32'((64'd8781922 * Q28 + E8 / 2) / E8),
    32'((64'd9930398 * Q28 + E8 / 2) / E8),
    32'((64'd11556 * Q28 + E5 / 2) / E5),
    32'((64'd1404344 * Q28 + E7 / 2) / E7),
    32'((64'd1836142 * Q28 + E7 / 2) / E7),
    32'((64'd2790016 * Q28 + E7 / 2) / E7),
    32'((64'd7010474 * Q28 + E7 / 2) / E7)
  };

  // Algorithm phase between uniforms
  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_C60   = 3'd1,
    PH_C80   = 3'd2,
    PH_C70   = 3'd3,
    PH_C40   = 3'd4,
    PH_TSTAR = 3'd5,
    PH_TU    = 3'd6,
    PH_T140  = 3'd7
  } phase_e;

  // Sequencer state within one uniform
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_TAIL,
    ST_MW,
    ST_MB,
    ST_MX,
    ST_EMIT
  } ctl_e;

  // Request to the shared multiplier
  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] op_a;
    logic [MUL_B_W-1:0] op_b;
  } mul_req_t;

endpackage

### hw/rtl/nvf_mul.sv
module nvf_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  nvf_pkg::mul_req_t                 req_i,
  output logic                              done_o,
  output logic [nvf_pkg::MUL_P_W-1:0]       prod_o
);

  logic [nvf_pkg::MUL_A_W-1:0] a_q;
  logic [nvf_pkg::MUL_B_W-1:0] b_q;
  logic [nvf_pkg::MUL_P_W-1:0] p_q;
  logic                        run_q;
  logic                        done_q;

  // Pipeline the start flag into the run and done flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= req_i.start;
      done_q <= run_q;
    end
  end

  // Capture operands on start, multiply them, register the product
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.op_a;
      b_q <= req_i.op_b;
    end
    if (run_q) begin
      p_q <= {{nvf_pkg::MUL_B_W{1'b0}}, a_q} * {{nvf_pkg::MUL_A_W{1'b0}}, b_q};
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

### hw/rtl/normal_variate_forsythe_fl_core.sv
// Standard normal deviate generator, Ahrens-Dieter FL method.
// Input channel: uniform_word_i with in_valid_i / in_ready_o, one Q0.32
// uniform per transaction. Output channel: deviate_o, signed Q4.28,
// with out_valid_o / out_ready_i. A deviate takes a variable number of
// uniforms; uniforms that do not finish a deviate produce no output.
// Each uniform needs only compares, one multiply, or two dependent
// multiplies, all on the one shared multiplier. The first uniform of a
// tail deviate also runs the doubling loop, one step per cycle, up to 33
// steps, before its two multiplies. A deviate that is ready is held in
// res_q and then loaded into the output register. in_ready_o is high
// only while the sequencer is idle. If the receiver stalls, the finished
// deviate holds in the output register and the next uniform is still
// accepted; it waits only if it too finishes a deviate. Reset returns
// the block to awaiting the first uniform of a deviate with no output
// pending.
module normal_variate_forsythe_fl_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] uniform_word_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic signed [31:0] deviate_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);

  nvf_pkg::ctl_e   ctl_q, ctl_d;
  nvf_pkg::phase_e phase_q, phase_d;
  logic        neg_q, neg_d;
  logic [4:0]  idx_q, idx_d;
  logic [31:0] base_q, base_d;
  logic [31:0] ustar_q, ustar_d;
  logic [31:0] w_q, w_d;
  logic [31:0] bound_q, bound_d;
  logic [31:0] r_q, r_d;
  logic [32:0] tf_q, tf_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] res_q, res_d;
  logic [31:0] out_q, out_d;
  logic        out_valid_q, out_valid_d;

  nvf_pkg::mul_req_t                mreq;
  logic                             mdone;
  logic [nvf_pkg::MUL_P_W-1:0]      mprod;

  // First-uniform decode
  logic        f_neg;
  logic [32:0] f_v;
  logic [4:0]  f_i;
  logic [32:0] f_ustar;
  logic [4:0]  f_im1;
  logic [4:0]  k_c60;
  logic [4:0]  slot;
  logic [33:0] tf2;
  logic [4:0]  idx_nx;
  logic [31:0] mw;
  logic [31:0] mbound;
  logic [31:0] qsum;
  logic [31:0] emit_w;
  logic [31:0] emit_y;
  logic [31:0] emit_mag;
  logic [31:0] emit_res;

  nvf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .done_o (mdone),
    .prod_o (mprod)
  );

  always_comb begin
    f_neg   = r_q > 32'h8000_0000;
    f_v     = {r_q, 1'b0} - (f_neg ? 33'h1_0000_0000 : 33'h0);
    f_i     = f_v[32] ? nvf_pkg::IDX_MAX : f_v[31:27];
    f_ustar = f_v[32] ? 33'h1_0000_0000 : {1'b0, f_v[26:0], 5'b0};
    f_im1   = f_i - 5'd1;
    k_c60   = (idx_q == 5'd0) ? 5'd1 : idx_q;
    slot    = k_c60 - 5'd1;
    tf2     = {tf_q, 1'b0};
    mw      = mprod[63:32];
    mbound  = (mprod[63:56] != 8'd0) ? 32'hFFFF_FFFF : mprod[55:24];
    qsum    = base_q + {1'b0, mw[31:1]};
  end

  // Sign and scale a finished deviate
  always_comb begin
    emit_w   = (ctl_q == nvf_pkg::ST_MX) ? mw : w_q;
    emit_y   = base_q + emit_w;
    emit_mag = emit_y >> nvf_pkg::OUT_SHIFT;
    emit_res = neg_q ? (32'd0 - emit_mag) : emit_mag;
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    ctl_d       = ctl_q;
    phase_d     = phase_q;
    neg_d       = neg_q;
    idx_d       = idx_q;
    base_d      = base_q;
    ustar_d     = ustar_q;
    w_d         = w_q;
    bound_d     = bound_q;
    r_d         = r_q;
    tf_d        = tf_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mreq        = '0;
    idx_nx      = idx_q;
    in_ready_o  = 1'b0;

    // Drop the output once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (ctl_q)
      nvf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          r_d   = uniform_word_i << nvf_pkg::UNI_SHIFT;
          ctl_d = nvf_pkg::ST_DISPATCH;
        end
      end

      nvf_pkg::ST_DISPATCH: begin
        ctl_d = nvf_pkg::ST_IDLE;
        unique case (phase_q)
          nvf_pkg::PH_FIRST: begin
            neg_d = f_neg;
            if (f_i != 5'd0) begin
              idx_d  = f_i;
              base_d = nvf_pkg::TAB_A[f_im1];
              if ({3'b0, f_ustar} <= {nvf_pkg::TAB_T[f_im1], 4'b0}) begin
                ustar_d = f_ustar[31:0];
                phase_d = nvf_pkg::PH_C60;
              end else begin
                mreq.start = 1'b1;
                mreq.op_a  = f_ustar - {1'b0, nvf_pkg::TAB_T[f_im1][27:0], 4'b0};
                mreq.op_b  = nvf_pkg::TAB_H[f_im1];
                ctl_d      = nvf_pkg::ST_MX;
              end
            end else begin
              idx_d  = nvf_pkg::TAIL_FIRST_IDX;
              base_d = nvf_pkg::TAB_A[nvf_pkg::IDX_MAX];
              tf_d   = f_ustar;
              cnt_d  = 6'd0;
              ctl_d  = nvf_pkg::ST_TAIL;
            end
          end
          nvf_pkg::PH_C60: begin
            mreq.start = 1'b1;
            mreq.op_a  = {1'b0, r_q};
            mreq.op_b  = nvf_pkg::TAB_A[k_c60] - base_q;
            ctl_d      = nvf_pkg::ST_MW;
          end
          nvf_pkg::PH_C80, nvf_pkg::PH_TU: begin
            if (ustar_q >= r_q) begin
              bound_d = r_q;
              phase_d = (phase_q == nvf_pkg::PH_TU) ? nvf_pkg::PH_TSTAR : nvf_pkg::PH_C70;
            end else begin
              phase_d = (phase_q == nvf_pkg::PH_TU) ? nvf_pkg::PH_T140 : nvf_pkg::PH_C40;
            end
          end
          nvf_pkg::PH_C70, nvf_pkg::PH_TSTAR: begin
            ustar_d = r_q;
            if (r_q > bound_q) begin
              res_d = emit_res;
              ctl_d = nvf_pkg::ST_EMIT;
            end else begin
              phase_d = (phase_q == nvf_pkg::PH_TSTAR) ? nvf_pkg::PH_TU : nvf_pkg::PH_C80;
            end
          end
          nvf_pkg::PH_C40: begin
            ustar_d = r_q;
            if ({4'b0, r_q} <= {nvf_pkg::TAB_T[slot], 4'b0}) begin
              phase_d = nvf_pkg::PH_C60;
            end else begin
              mreq.start = 1'b1;
              mreq.op_a  = {1'b0, r_q} - {1'b0, nvf_pkg::TAB_T[slot][27:0], 4'b0};
              mreq.op_b  = nvf_pkg::TAB_H[slot];
              ctl_d      = nvf_pkg::ST_MX;
            end
          end
          nvf_pkg::PH_T140: begin
            mreq.start = 1'b1;
            mreq.op_a  = {1'b0, r_q};
            mreq.op_b  = nvf_pkg::TAB_D[slot];
            ctl_d      = nvf_pkg::ST_MW;
          end
          default: ;
        endcase
      end

      // One doubling per cycle; stop on overflow or after the last step
      nvf_pkg::ST_TAIL: begin
        cnt_d = cnt_q + 6'd1;
        if (tf2[32]) begin
          mreq.start = 1'b1;
          mreq.op_a  = {1'b0, tf2[31:0]};
          mreq.op_b  = nvf_pkg::TAB_D[idx_q - 5'd1];
          ctl_d      = nvf_pkg::ST_MW;
        end else begin
          tf_d = tf2[32:0];
          if (idx_q < nvf_pkg::IDX_MAX) begin
            base_d = base_q + nvf_pkg::TAB_D[idx_q - 5'd1];
            idx_nx = idx_q + 5'd1;
          end
          idx_d = idx_nx;
          if (cnt_q == nvf_pkg::TAIL_LAST_STEP) begin
            mreq.start = 1'b1;
            mreq.op_a  = '0;
            mreq.op_b  = nvf_pkg::TAB_D[idx_nx - 5'd1];
            ctl_d      = nvf_pkg::ST_MW;
          end
        end
      end

      // Product gives w; issue the quadratic bound
      nvf_pkg::ST_MW: begin
        if (mdone) begin
          w_d        = mw;
          mreq.start = 1'b1;
          mreq.op_a  = {1'b0, qsum};
          mreq.op_b  = mw;
          ctl_d      = nvf_pkg::ST_MB;
        end
      end

      nvf_pkg::ST_MB: begin
        if (mdone) begin
          bound_d = mbound;
          ctl_d   = nvf_pkg::ST_IDLE;
          if (phase_q == nvf_pkg::PH_C60) begin
            if (ustar_q > mbound) begin
              res_d = emit_res;
              ctl_d = nvf_pkg::ST_EMIT;
            end else begin
              phase_d = nvf_pkg::PH_C80;
            end
          end else begin
            phase_d = nvf_pkg::PH_TSTAR;
          end
        end
      end

      nvf_pkg::ST_MX: begin
        if (mdone) begin
          res_d = emit_res;
          ctl_d = nvf_pkg::ST_EMIT;
        end
      end

      // Hold until the output register is free
      nvf_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          phase_d     = nvf_pkg::PH_FIRST;
          ctl_d       = nvf_pkg::ST_IDLE;
        end
      end

      default: ctl_d = nvf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= nvf_pkg::ST_IDLE;
      phase_q     <= nvf_pkg::PH_FIRST;
      neg_q       <= 1'b0;
      idx_q       <= 5'd0;
      base_q      <= 32'd0;
      ustar_q     <= 32'd0;
      w_q         <= 32'd0;
      bound_q     <= 32'd0;
      cnt_q       <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      ctl_q       <= ctl_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      idx_q       <= idx_d;
      base_q      <= base_d;
      ustar_q     <= ustar_d;
      w_q         <= w_d;
      bound_q     <= bound_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    tf_q  <= tf_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign deviate_o   = out_q;
  assign out_valid_o = out_valid_q;

  // A product arrives only while the sequencer waits for one
  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdone |-> (ctl_q == nvf_pkg::ST_MW || ctl_q == nvf_pkg::ST_MB ||
               ctl_q == nvf_pkg::ST_MX))
    else $error("multiplier result outside a wait state");

  // An accepted transaction closes the input until it is processed
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // The doubling loop stays within its index range and step count
  a_tail_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q == nvf_pkg::ST_TAIL) |-> (idx_q >= nvf_pkg::TAIL_FIRST_IDX &&
                                     cnt_q <= nvf_pkg::TAIL_LAST_STEP))
    else $error("tail loop out of range");

  // Loading the output never overwrites a pending deviate
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q == nvf_pkg::ST_EMIT && out_valid_q && !out_ready_i) |=>
      (ctl_q == nvf_pkg::ST_EMIT))
    else $error("pending deviate overwritten");

endmodule

### bench/tb_normal_variate_forsythe_fl_core.sv
`timescale 1ns / 1ps

module tb_normal_variate_forsythe_fl_core;

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [31:0] uniform_word_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic signed [31:0] deviate_o;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;

  normal_variate_forsythe_fl_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .uniform_word_i (uniform_word_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .deviate_o      (deviate_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

  always #2 clk_i = ~clk_i;

  // Generator state mirrored in the bench
  nvf_pkg::phase_e gen_phase;
  logic        gen_neg;
  logic [4:0]  gen_idx;
  logic [31:0] gen_aa, gen_ustar, gen_w, gen_tt;

  logic [31:0] pending_uniforms[$];
  logic [31:0] expected_deviates[$];
  int unsigned idle_pct, stall_pct;
  bit          hold_sender;
  int unsigned failures, quiet_cycles;
  bit          stim_done;

  function automatic logic [31:0] mul_frac(logic [31:0] u, logic [31:0] q);
    logic [63:0] p;
    p = {32'd0, u} * {32'd0, q};
    return p[63:32];
  endfunction

  function automatic logic [31:0] bound_of(logic [31:0] aa, logic [31:0] w);
    logic [31:0] s;
    logic [63:0] p;
    s = aa + (w >> 1);
    p = ({32'd0, s} * {32'd0, w}) >> 24;
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  function automatic logic [4:0] tab_slot();
    logic [4:0] i;
    i = (gen_idx == 5'd0) ? 5'd1 : gen_idx;
    return i - 5'd1;
  endfunction

  // Finish a deviate: add base, rescale, apply sign
  function automatic void push_deviate(logic [31:0] w);
    logic [31:0] y, mag;
    y = gen_aa + w;
    mag = y >> nvf_pkg::OUT_SHIFT;
    expected_deviates.push_back(gen_neg ? (32'd0 - mag) : mag);
    gen_phase = nvf_pkg::PH_FIRST;
  endfunction

  function automatic void centre_exit(logic [63:0] ustar);
    logic [4:0]  k;
    logic [63:0] d;
    logic [127:0] p;
    k = tab_slot();
    d = ustar - ({32'd0, nvf_pkg::TAB_T[k]} << 4);
    p = {64'd0, d} * {96'd0, nvf_pkg::TAB_H[k]};
    push_deviate(p[63:32]);
  endfunction

  // Advance the generator by one uniform
  function automatic void step_generator(logic [31:0] word);
    logic [31:0] r, k;
    logic [63:0] v, x, ustar, f;
    logic [31:0] i;
    bit hit;
    r = word << nvf_pkg::UNI_SHIFT;
    case (gen_phase)
      nvf_pkg::PH_FIRST: begin
        gen_neg = r > 32'h8000_0000;
        v = ({32'd0, r} << 1) - (gen_neg ? 64'h1_0000_0000 : 64'd0);
        x = v << 5;
        i = x[63:32];
        if (i > 31) i = 31;
        ustar = x - ({32'd0, i} << 32);
        if (i != 0) begin
          gen_idx = i[4:0];
          gen_aa = nvf_pkg::TAB_A[i - 1];
          if (ustar <= ({32'd0, nvf_pkg::TAB_T[i - 1]} << 4)) begin
            gen_ustar = ustar[31:0];
            gen_phase = nvf_pkg::PH_C60;
          end else begin
            centre_exit(ustar);
          end
        end else begin
          f = ustar;
          hit = 0;
          i = 6;
          gen_aa = nvf_pkg::TAB_A[31];
          for (int n = 0; n < 33 && !hit; n++) begin
            f = f << 1;
            if (f >= 64'h1_0000_0000) begin
              f -= 64'h1_0000_0000;
              hit = 1;
            end else if (i < 31) begin
              gen_aa += nvf_pkg::TAB_D[i - 1];
              i++;
            end
          end
          if (!hit) f = 0;
          gen_idx = i[4:0];
          gen_w = mul_frac(f[31:0], nvf_pkg::TAB_D[i - 1]);
          gen_tt = bound_of(gen_aa, gen_w);
          gen_phase = nvf_pkg::PH_TSTAR;
        end
      end
      nvf_pkg::PH_C60: begin
        k = (gen_idx == 5'd0) ? 32'd1 : {27'd0, gen_idx};
        gen_w = mul_frac(r, nvf_pkg::TAB_A[k] - gen_aa);
        gen_tt = bound_of(gen_aa, gen_w);
        if (gen_ustar > gen_tt) push_deviate(gen_w);
        else gen_phase = nvf_pkg::PH_C80;
      end
      nvf_pkg::PH_C80, nvf_pkg::PH_TU: begin
        if (gen_ustar >= r) begin
          gen_tt = r;
          gen_phase = (gen_phase == nvf_pkg::PH_TU) ? nvf_pkg::PH_TSTAR : nvf_pkg::PH_C70;
        end else begin
          gen_phase = (gen_phase == nvf_pkg::PH_TU) ? nvf_pkg::PH_T140 : nvf_pkg::PH_C40;
        end
      end
      nvf_pkg::PH_C70, nvf_pkg::PH_TSTAR: begin
        gen_ustar = r;
        if (r > gen_tt) push_deviate(gen_w);
        else gen_phase = (gen_phase == nvf_pkg::PH_TSTAR) ? nvf_pkg::PH_TU : nvf_pkg::PH_C80;
      end
      nvf_pkg::PH_C40: begin
        gen_ustar = r;
        if ({32'd0, r} <= ({32'd0, nvf_pkg::TAB_T[tab_slot()]} << 4)) begin
          gen_phase = nvf_pkg::PH_C60;
        end else begin
          centre_exit({32'd0, r});
        end
      end
      default: begin
        gen_w = mul_frac(r, nvf_pkg::TAB_D[tab_slot()]);
        gen_tt = bound_of(gen_aa, gen_w);
        gen_phase = nvf_pkg::PH_TSTAR;
      end
    endcase
  endfunction

  // Driver: present uniforms, hold until the transaction completes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        step_generator(uniform_word_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_uniforms.size() != 0 && !hold_sender &&
            $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          uniform_word_i <= pending_uniforms.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          uniform_word_i <= $urandom;
        end
      end
    end
  end

  // Monitor: check deviates, drive backpressure, run the watchdog
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_deviates.size() == 0) begin
          $error("deviate: unexpected result %h", deviate_o);
          failures++;
        end else begin
          want = expected_deviates.pop_front();
          if (deviate_o !== want) begin
            $error("deviate: expected %h actual %h", want, deviate_o);
            failures++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT && !stim_done) begin
        $display("tb_normal_variate_forsythe_fl_core: errors");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_uniforms.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_deviates.size() != 0) @(posedge clk_i);
  endtask

  // Random deviate starts: centre, near-tail and deep-tail words
  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return $urandom_range(32'h0400_0000);
      1: return 32'h8000_0000 + $urandom_range(32'h0400_0000);
      2: return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    gen_phase = nvf_pkg::PH_FIRST;
    gen_neg = 0; gen_idx = 0; gen_aa = 0; gen_ustar = 0; gen_w = 0; gen_tt = 0;
    idle_pct = 0; stall_pct = 0; hold_sender = 0;
    failures = 0; quiet_cycles = 0; stim_done = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, exactly one half, tail start and deep tail
    pending_uniforms = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0001,
      32'h7FFF_FFFF, 32'h0000_0001, 32'h0400_0000, 32'h03FF_FFFF,
      32'h8400_0000, 32'h8000_0002, 32'h5555_5555, 32'hAAAA_AAAA,
      32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
      32'h1234_5678, 32'h0010_0000, 32'h8000_0000, 32'hFFFF_FFFF};
    wait_drained();

    // Sender pauses until every deviate is out
    hold_sender = 1;
    wait_drained();
    repeat (60) @(posedge clk_i);
    hold_sender = 0;

    // Random phases with different idle and stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 51 : 24) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 51 : 24) : 0;
      for (int n = 0; n < 333; n++) pending_uniforms.push_back(rand_word());
      wait_drained();
    end

    stim_done = 1;
    repeat (100) @(posedge clk_i);
    if (failures == 0) begin
      $display("tb_normal_variate_forsythe_fl_core: clean");
    end else begin
      $display("tb_normal_variate_forsythe_fl_core: errors");
    end
    $finish;
  end

  // Bound on the drain at the end
  initial begin
    wait (stim_done);
    repeat (20000) @(posedge clk_i);
    $display("tb_normal_variate_forsythe_fl_core: errors");
    $finish;
  end

endmodule
